// File: hdl/ftlcm_pkg.sv
package ftlcm_pkg;

    localparam int unsigned IN_W    = 20;
    localparam int unsigned LIM_W   = 19;
    localparam int unsigned SQ_W    = 2 * IN_W;
    localparam int unsigned BURST_W = 8;
    localparam int unsigned HOLD_W  = 16;

    localparam logic [BURST_W-1:0] BURST_LIMIT   = 8'd5;
    localparam logic [HOLD_W-1:0]  HOLDOFF_TICKS = 16'd100;

    localparam logic [LIM_W-1:0] FORCE_UNBIASED_RST  = 19'd50000;
    localparam logic [LIM_W-1:0] TORQUE_UNBIASED_RST = 19'd5000;
    localparam logic [LIM_W-1:0] FORCE_BIASED_RST    = 19'd10000;
    localparam logic [LIM_W-1:0] TORQUE_BIASED_RST   = 19'd800;
    localparam logic [LIM_W-1:0] BIASED_LIMIT_MIN    = 19'd1;

    localparam logic [1:0] CFG_FORCE_UNBIASED  = 2'd0;
    localparam logic [1:0] CFG_TORQUE_UNBIASED = 2'd1;
    localparam logic [1:0] CFG_FORCE_BIASED    = 2'd2;
    localparam logic [1:0] CFG_TORQUE_BIASED   = 2'd3;

    localparam logic [1:0] BIAS_NONE    = 2'd0;
    localparam logic [1:0] BIAS_TAKEN   = 2'd1;
    localparam logic [1:0] BIAS_REMOVED = 2'd2;
    localparam logic [1:0] BIAS_UNUSED  = 2'd3;

    typedef struct packed {
        logic signed [IN_W-1:0] force_x;
        logic signed [IN_W-1:0] force_y;
        logic signed [IN_W-1:0] force_z;
        logic signed [IN_W-1:0] torque_x;
        logic signed [IN_W-1:0] torque_y;
        logic signed [IN_W-1:0] torque_z;
        logic [1:0]             bias_command;
    } sample_t;

    typedef struct packed {
        logic cancel;
        logic over_limit;
        logic biased_limits_used;
    } result_t;

    typedef struct packed {
        logic [SQ_W-1:0] force_x;
        logic [SQ_W-1:0] force_y;
        logic [SQ_W-1:0] force_z;
        logic [SQ_W-1:0] torque_x;
        logic [SQ_W-1:0] torque_y;
        logic [SQ_W-1:0] torque_z;
    } squares_t;

endpackage

// File: hdl/force_torque_limit_cancel_monitor.sv
// channel   signals                                   request
// config    cfg_write, cfg_index[1:0], cfg_data[18:0]  one register write per enabled edge
// sample    sample_valid, sample_ready, sample         one wrench sample and bias command
// result    result_valid, result_ready, result         cancel, over_limit, biased_limits_used
//
// one request per cycle unless stalled; input register, one pass into the result register
// result is registered on the edge after acceptance when the result register is free
// bias flags and burst and holdoff counters update as a request enters the result register
// rst_n clears both valids and flags, reloads the counters and restores the reset limits
// a stalled result backs up the input register; sample_ready drops only when both are full
module force_torque_limit_cancel_monitor (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [1:0]                       cfg_index,
    input  logic [ftlcm_pkg::LIM_W-1:0]      cfg_data,
    input  logic                             sample_valid,
    output logic                             sample_ready,
    input  ftlcm_pkg::sample_t               sample,
    output logic                             result_valid,
    input  logic                             result_ready,
    output ftlcm_pkg::result_t               result
);
    import ftlcm_pkg::*;

    logic [LIM_W-1:0] force_unb_reg, torque_unb_reg, force_bia_reg, torque_bia_reg;

    logic             v1_reg, v2_reg;
    sample_t          s1_reg;
    result_t          result_reg;

    logic               biased_reg, biased_next;
    logic               new_bias_reg, new_bias_next;
    logic [BURST_W-1:0] burst_reg, burst_next;
    logic [HOLD_W-1:0]  holdoff_reg, holdoff_next;

    logic en1, en2;
    squares_t sq1;
    logic use_biased1;
    logic [LIM_W-1:0] flim1, tlim1;
    logic [SQ_W-1:0] flim_sq1, tlim_sq1;
    logic [SQ_W-1:0] fsq, tsq;
    logic over, cancel_next;

    assign en2 = !v2_reg || result_ready;
    assign en1 = !v1_reg || en2;
    assign sample_ready = en1;
    assign result_valid = v2_reg;
    assign result = result_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            force_unb_reg  <= FORCE_UNBIASED_RST;
            torque_unb_reg <= TORQUE_UNBIASED_RST;
            force_bia_reg  <= FORCE_BIASED_RST;
            torque_bia_reg <= TORQUE_BIASED_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FORCE_UNBIASED:
                begin
                    if (cfg_data != '0)
                    begin
                        force_unb_reg <= cfg_data;
                    end
                end
                CFG_TORQUE_UNBIASED: torque_unb_reg <= cfg_data;
                CFG_FORCE_BIASED:    force_bia_reg  <= cfg_data;
                CFG_TORQUE_BIASED:   torque_bia_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // squares, bias flags, limit selection
    ftlcm_square u_square (
        .sample  (s1_reg),
        .squares (sq1)
    );

    always_comb
    begin
        biased_next   = biased_reg;
        new_bias_next = new_bias_reg;
        unique case (s1_reg.bias_command)
            BIAS_TAKEN:
            begin
                biased_next   = 1'b1;
                new_bias_next = 1'b1;
            end
            BIAS_REMOVED: biased_next = 1'b0;
            BIAS_NONE, BIAS_UNUSED: ;
            default: ;
        endcase
        use_biased1 = biased_next && !new_bias_next &&
                      (force_bia_reg > BIASED_LIMIT_MIN) && (torque_bia_reg > BIASED_LIMIT_MIN);
        if (biased_next && new_bias_next)
        begin
            new_bias_next = 1'b0;
        end
        flim1 = use_biased1 ? force_bia_reg  : force_unb_reg;
        tlim1 = use_biased1 ? torque_bia_reg : torque_unb_reg;
    end

    // magnitude compare and cancel sequencing
    assign flim_sq1 = SQ_W'(flim1) * SQ_W'(flim1);
    assign tlim_sq1 = SQ_W'(tlim1) * SQ_W'(tlim1);
    assign fsq  = sq1.force_x + sq1.force_y + sq1.force_z;
    assign tsq  = sq1.torque_x + sq1.torque_y + sq1.torque_z;
    assign over = (fsq > flim_sq1) || (tsq > tlim_sq1);

    always_comb
    begin
        cancel_next  = 1'b0;
        burst_next   = burst_reg;
        holdoff_next = holdoff_reg;
        priority if (over && (burst_reg != '0))
        begin
            cancel_next = 1'b1;
            burst_next  = burst_reg - 1'b1;
        end
        else if ((burst_reg == '0) && (holdoff_reg != '0) && (holdoff_reg <= HOLDOFF_TICKS))
        begin
            holdoff_next = holdoff_reg - 1'b1;
        end
        else if ((holdoff_reg == '0) || !over)
        begin
            burst_next   = BURST_LIMIT;
            holdoff_next = HOLDOFF_TICKS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            biased_reg   <= 1'b0;
            new_bias_reg <= 1'b0;
            burst_reg    <= BURST_LIMIT;
            holdoff_reg  <= HOLDOFF_TICKS;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= sample_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
                if (v1_reg)
                begin
                    biased_reg   <= biased_next;
                    new_bias_reg <= new_bias_next;
                    burst_reg    <= burst_next;
                    holdoff_reg  <= holdoff_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= sample;
        end
        if (en2)
        begin
            result_reg.cancel             <= cancel_next;
            result_reg.over_limit         <= over;
            result_reg.biased_limits_used <= use_biased1;
        end
    end

endmodule

// File: hdl/ftlcm_square.sv
module ftlcm_square (
    input  ftlcm_pkg::sample_t  sample,
    output ftlcm_pkg::squares_t squares
);
    import ftlcm_pkg::*;

    function automatic logic [SQ_W-1:0] square_of(input logic signed [IN_W-1:0] v);
        logic [IN_W-1:0] mag;
        mag = v[IN_W-1] ? (~v + 1'b1) : v;
        return mag * mag;
    endfunction

    assign squares.force_x  = square_of(sample.force_x);
    assign squares.force_y  = square_of(sample.force_y);
    assign squares.force_z  = square_of(sample.force_z);
    assign squares.torque_x = square_of(sample.torque_x);
    assign squares.torque_y = square_of(sample.torque_y);
    assign squares.torque_z = square_of(sample.torque_z);

endmodule

// File: hdl/ftlcm_checker.sv
module ftlcm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        sample_ready,
    input logic                        result_valid,
    input logic                        result_ready,
    input ftlcm_pkg::result_t          result
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed");

    // cancel only on an over-limit sample
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (!result.cancel || result.over_limit))
        else $error("cancel without over limit");

    // empty output means the block can take a request
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> sample_ready)
        else $error("sample stalled with empty output");

    // no result right after reset release
    assert property (@(posedge clk)
        $rose(rst_n) |-> !result_valid)
        else $error("result valid out of reset");

endmodule

bind force_torque_limit_cancel_monitor ftlcm_checker u_ftlcm_checker (.*);

// File: bench/tb.sv
`timescale 1ns / 100ps

module tb;
    import ftlcm_pkg::*;

    localparam int CLK_PERIOD       = 20;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam logic [LIM_W-1:0] LIM_MAX = '1;

    typedef enum int {TRAFFIC_QUIET, TRAFFIC_LOUD, TRAFFIC_MIXED} traffic_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic [1:0]         cfg_index;
    logic [LIM_W-1:0]   cfg_data;
    logic               sample_valid;
    logic               sample_ready;
    sample_t            sample;
    logic               result_valid;
    logic               result_ready;
    result_t            result;

    force_torque_limit_cancel_monitor uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // predictor copy of the limits and the monitor state
    logic [LIM_W-1:0]   lim_force_u  = FORCE_UNBIASED_RST;
    logic [LIM_W-1:0]   lim_torque_u = TORQUE_UNBIASED_RST;
    logic [LIM_W-1:0]   lim_force_b  = FORCE_BIASED_RST;
    logic [LIM_W-1:0]   lim_torque_b = TORQUE_BIASED_RST;
    logic               bias_held    = 1'b0;
    logic               bias_fresh   = 1'b0;
    logic [BURST_W-1:0] burst_left   = BURST_LIMIT;
    logic [HOLD_W-1:0]  holdoff_left = HOLDOFF_TICKS;

    result_t pending_results[$];
    result_t due;
    int      mismatches   = 0;
    bit      sample_gaps  = 1'b0;
    bit      results_idle = 1'b0;
    bit      long_hold    = 1'b0;

    function automatic longint unsigned mag_sq(logic signed [IN_W-1:0] v);
        longint m;
        m = longint'(v);
        if (m < 0)
            m = -m;
        return m * m;
    endfunction

    function automatic result_t predict_monitor(sample_t s);
        longint unsigned f_sq;
        longint unsigned t_sq;
        longint unsigned f_lim;
        longint unsigned t_lim;
        result_t r;
        f_sq = mag_sq(s.force_x) + mag_sq(s.force_y) + mag_sq(s.force_z);
        t_sq = mag_sq(s.torque_x) + mag_sq(s.torque_y) + mag_sq(s.torque_z);
        r = '0;
        if (s.bias_command == BIAS_TAKEN)
        begin
            bias_held = 1'b1;
            bias_fresh = 1'b1;
        end
        else if (s.bias_command == BIAS_REMOVED)
            bias_held = 1'b0;
        if (bias_held && !bias_fresh)
            r.biased_limits_used = (lim_force_b > BIASED_LIMIT_MIN) &&
                                   (lim_torque_b > BIASED_LIMIT_MIN);
        else if (bias_held && bias_fresh)
            bias_fresh = 1'b0;
        f_lim = 64'(r.biased_limits_used ? lim_force_b : lim_force_u);
        t_lim = 64'(r.biased_limits_used ? lim_torque_b : lim_torque_u);
        r.over_limit = (f_sq > f_lim * f_lim) || (t_sq > t_lim * t_lim);
        if (r.over_limit && burst_left != 0)
        begin
            r.cancel = 1'b1;
            burst_left = burst_left - 1'b1;
        end
        else if (burst_left == 0 && holdoff_left != 0 && holdoff_left <= HOLDOFF_TICKS)
            holdoff_left = holdoff_left - 1'b1;
        else if (holdoff_left == 0 || !r.over_limit)
        begin
            burst_left = BURST_LIMIT;
            holdoff_left = HOLDOFF_TICKS;
        end
        return r;
    endfunction

    function automatic int unsigned pick_gap();
        return ($urandom_range(99) < 85) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    endfunction

    function automatic sample_t wrench(logic signed [IN_W-1:0] fx, fy, fz, tx, ty, tz,
                                       logic [1:0] bias);
        sample_t s;
        s.force_x = fx;
        s.force_y = fy;
        s.force_z = fz;
        s.torque_x = tx;
        s.torque_y = ty;
        s.torque_z = tz;
        s.bias_command = bias;
        return s;
    endfunction

    function automatic logic signed [IN_W-1:0] bounded_comp(int unsigned span);
        int unsigned m;
        m = $urandom_range(span, 0);
        return IN_W'($urandom_range(1) ? -m : m);
    endfunction

    function automatic logic signed [IN_W-1:0] mixed_comp(int unsigned span);
        logic [31:0] raw;
        raw = $urandom();
        case ($urandom_range(9))
            0:
            begin
                case ($urandom_range(4))
                    0: return {1'b1, {(IN_W-1){1'b0}}};
                    1: return {1'b0, {(IN_W-1){1'b1}}};
                    2: return '0;
                    3: return '1;
                    default: return 1;
                endcase
            end
            1, 2, 3, 4: return bounded_comp(span);
            default: return raw[IN_W-1:0];
        endcase
    endfunction

    function automatic logic [1:0] random_bias();
        case ($urandom_range(9))
            0: return BIAS_TAKEN;
            1: return BIAS_REMOVED;
            2: return BIAS_UNUSED;
            default: return BIAS_NONE;
        endcase
    endfunction

    function automatic sample_t random_wrench(traffic_t mode);
        int unsigned quiet_span;
        int unsigned f_span;
        int unsigned t_span;
        sample_t s;
        quiet_span = 32'(lim_force_u);
        if (32'(lim_torque_u) < quiet_span) quiet_span = 32'(lim_torque_u);
        if (32'(lim_force_b) < quiet_span) quiet_span = 32'(lim_force_b);
        if (32'(lim_torque_b) < quiet_span) quiet_span = 32'(lim_torque_b);
        quiet_span = quiet_span / 2;
        f_span = 32'($urandom_range(1) ? lim_force_u : lim_force_b);
        t_span = 32'($urandom_range(1) ? lim_torque_u : lim_torque_b);
        if (mode == TRAFFIC_QUIET)
            s = wrench(bounded_comp(quiet_span), bounded_comp(quiet_span),
                       bounded_comp(quiet_span), bounded_comp(quiet_span),
                       bounded_comp(quiet_span), bounded_comp(quiet_span), random_bias());
        else
            s = wrench(mixed_comp(f_span), mixed_comp(f_span), mixed_comp(f_span),
                       mixed_comp(t_span), mixed_comp(t_span), mixed_comp(t_span),
                       random_bias());
        if (mode == TRAFFIC_LOUD)
        begin
            case ($urandom_range(5))
                0: s.force_x = bounded_comp(524287);
                1: s.force_y = bounded_comp(524287);
                2: s.force_z = bounded_comp(524287);
                3: s.torque_x = bounded_comp(524287);
                4: s.torque_y = bounded_comp(524287);
                default: s.torque_z = bounded_comp(524287);
            endcase
        end
        return s;
    endfunction

    // one request per call, prediction at the accepting edge
    task automatic offer_sample(input sample_t s);
        int unsigned gap;
        sample <= s;
        sample_valid <= 1'b1;
        do
            @(posedge clk);
        while (sample_ready !== 1'b1);
        pending_results.push_back(predict_monitor(s));
        gap = (sample_gaps && $urandom_range(99) < 35) ? pick_gap() : 0;
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        sample_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_limit(input logic [1:0] idx, input logic [LIM_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_FORCE_UNBIASED:
            begin
                if (value != 0)
                    lim_force_u = value;
            end
            CFG_TORQUE_UNBIASED: lim_torque_u = value;
            CFG_FORCE_BIASED: lim_force_b = value;
            default: lim_torque_b = value;
        endcase
    endtask

    task automatic program_limits(input logic [LIM_W-1:0] fu, tu, fb, tq_b);
        wait_idle();
        write_limit(CFG_FORCE_UNBIASED, fu);
        write_limit(CFG_TORQUE_UNBIASED, tu);
        write_limit(CFG_FORCE_BIASED, fb);
        write_limit(CFG_TORQUE_BIASED, tq_b);
        cfg_write <= 1'b0;
    endtask

    task automatic test_reset_limits();
        offer_sample(wrench(0, 0, 0, 0, 0, 0, BIAS_NONE));
        offer_sample(wrench(50000, 0, 0, 0, 0, 0, BIAS_NONE));
        offer_sample(wrench(50001, 0, 0, 0, 0, 0, BIAS_NONE));
        offer_sample(wrench(0, 0, 0, 0, 0, -5001, BIAS_NONE));
        offer_sample(wrench(524287, 524287, 524287, 524287, 524287, 524287, BIAS_NONE));
        offer_sample(wrench(-524288, -524288, -524288, -524288, -524288, -524288,
                            BIAS_UNUSED));
        offer_sample(wrench(0, 30000, -40000, 3000, 0, 4000, BIAS_NONE));
    endtask

    task automatic test_bias_handling();
        offer_sample(wrench(10001, 0, 0, 0, 0, 0, BIAS_TAKEN));
        offer_sample(wrench(10001, 0, 0, 0, 0, 0, BIAS_NONE));
        offer_sample(wrench(10000, 0, 0, 800, 0, 0, BIAS_NONE));
        offer_sample(wrench(0, 0, 0, 0, -801, 0, BIAS_NONE));
        offer_sample(wrench(0, 0, 0, 0, 801, 0, BIAS_TAKEN));
        offer_sample(wrench(0, 0, -10001, 0, 0, 0, BIAS_UNUSED));
        offer_sample(wrench(10001, 0, 0, 0, 0, 0, BIAS_REMOVED));
        offer_sample(wrench(0, 0, 0, 0, 0, 801, BIAS_NONE));
    endtask

    task automatic test_limit_registers();
        // zero unbiased force limit is dropped, biased pair off with a limit of one
        program_limits(0, 0, 1, LIM_MAX);
        offer_sample(wrench(50000, 0, 0, 0, 0, 0, BIAS_TAKEN));
        offer_sample(wrench(0, 0, 0, 1, 0, 0, BIAS_NONE));
        program_limits(LIM_MAX, LIM_MAX, 2, 2);
        offer_sample(wrench(2, 0, 0, 0, 0, -2, BIAS_NONE));
        offer_sample(wrench(0, -3, 0, 0, 0, 0, BIAS_NONE));
        program_limits(1, LIM_MAX, LIM_MAX, LIM_MAX);
        offer_sample(wrench(1, 0, 0, 0, 0, 0, BIAS_REMOVED));
        offer_sample(wrench(0, 0, -2, 0, 0, 0, BIAS_NONE));
    endtask

    task automatic run_random_phase(input logic [LIM_W-1:0] fu, tu, fb, tq_b,
                                    input int unsigned count);
        int unsigned sent;
        int unsigned run_len;
        traffic_t mode;
        program_limits(fu, tu, fb, tq_b);
        sent = 0;
        while (sent < count)
        begin
            mode = traffic_t'($urandom_range(2));
            run_len = $urandom_range(40, 3);
            sample_gaps = ($urandom_range(3) != 0);
            results_idle = ($urandom_range(3) != 0);
            repeat (run_len)
            begin
                offer_sample(random_wrench(mode));
                sent++;
            end
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(FORCE_UNBIASED_RST, TORQUE_UNBIASED_RST, FORCE_BIASED_RST,
                         TORQUE_BIASED_RST, 285);
        run_random_phase(LIM_MAX, LIM_MAX, LIM_MAX, LIM_MAX, 285);
        run_random_phase(1, 0, 2, 2, 285);
        run_random_phase(300000, 200000, 0, 0, 285);
        run_random_phase(LIM_W'($urandom_range(524287, 1)), LIM_W'($urandom_range(524287, 0)),
                         LIM_W'($urandom_range(524287, 0)), LIM_W'($urandom_range(524287, 0)),
                         285);
        run_random_phase(FORCE_UNBIASED_RST, TORQUE_UNBIASED_RST, FORCE_BIASED_RST,
                         TORQUE_BIASED_RST, 285);
    endtask

    task automatic test_input_backpressure();
        wait_idle();
        sample_gaps = 1'b0;
        results_idle = 1'b0;
        long_hold = 1'b1;
        repeat (30) offer_sample(random_wrench(TRAFFIC_MIXED));
        wait_idle();
    endtask

    // receiver side stalls
    initial
    begin
        forever
        begin
            if (long_hold)
            begin
                result_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (results_idle && $urandom_range(99) < 30)
            begin
                result_ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
            else
            begin
                result_ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    task automatic compare_field(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $display("%0t: %s expected %b actual %b", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result with none expected, actual %b", $time, result);
                mismatches++;
            end
            else
            begin
                due = pending_results.pop_front();
                compare_field("cancel", due.cancel, result.cancel);
                compare_field("over_limit", due.over_limit, result.over_limit);
                compare_field("biased_limits_used", due.biased_limits_used,
                              result.biased_limits_used);
            end
        end
    end

    initial
    begin
        #(10_000_000);
        $display("force_torque_limit_cancel_monitor regression: fail");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_FORCE_UNBIASED;
        cfg_data <= '0;
        sample_valid <= 1'b0;
        sample <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_limits();
        test_bias_handling();
        test_limit_registers();
        test_random_traffic();
        test_input_backpressure();
        wait_idle();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("force_torque_limit_cancel_monitor regression: pass");
        else
            $display("force_torque_limit_cancel_monitor regression: fail");
        $finish;
    end

endmodule

// File: force_torque_limit_cancel_monitor.f
hdl/ftlcm_pkg.sv
hdl/ftlcm_square.sv
hdl/force_torque_limit_cancel_monitor.sv
hdl/ftlcm_checker.sv
bench/tb.sv
